### rtl/sisl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sisl_pkg
// Shared types and constants of the sorted table lookup with a sparse index.
// ----------------------------------------------------------------------------
package sisl_pkg;

	localparam int INDEX_DEPTH_DEF = 256;
	localparam int DATA_DEPTH_DEF  = 4096;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 12;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR       = 2'd0,
		OP_IDX_APPEND  = 2'd1,
		OP_DATA_APPEND = 2'd2,
		OP_LOOKUP      = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NOT_FOUND = 3'd0,
		ST_FOUND     = 3'd1,
		ST_DELETED   = 3'd2,
		ST_ACCEPTED  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]        pos;
	} idx_entry_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
		logic                    tomb;
	} data_entry_t;

endpackage
`default_nettype wire

### rtl/sisl_index_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sisl_index_store
// Sparse index memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sisl_index_store #(
	parameter int DEPTH = sisl_pkg::INDEX_DEPTH_DEF,
	parameter int AW    = 8
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire sisl_pkg::idx_entry_t wr_entry,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output sisl_pkg::idx_entry_t      rd_entry
);
	import sisl_pkg::*;

	idx_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/sisl_data_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sisl_data_store
// Data table memory of key, value and deleted mark; registered read port.
// ----------------------------------------------------------------------------
module sisl_data_store #(
	parameter int DEPTH = sisl_pkg::DATA_DEPTH_DEF,
	parameter int AW    = 12
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire sisl_pkg::data_entry_t wr_entry,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr,
	output sisl_pkg::data_entry_t      rd_entry
);
	import sisl_pkg::*;

	data_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/sparse_index_sorted_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_index_sorted_lookup
// Key-sorted data table with a sparse index; clear, append and lookup.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (req_valid, req_stall) and each request
// beat produces exactly one response beat on the rsp channel (rsp_valid,
// rsp_stall), in order. The response is held in an output register.
// Clear and both appends finish in the cycle of acceptance; their response
// appears in the next cycle, and the next request can be taken then unless
// rsp_stall holds that response. A lookup binary-searches the index memory
// and then scans the data memory. Each search step and each scanned entry has
// a read state that issues the read and a compare state that compares the
// registered read data. An empty index skips the search; the scan stops at an
// equal key, a greater key or the last written entry, and a final state then
// loads the response register once the output is free.
// One lookup is in flight at a time; req_stall is high while it runs and while
// a finished response is held by rsp_stall. A stalled response stays stable.
// Reset empties both tables at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sparse_index_sorted_lookup #(
	parameter int INDEX_DEPTH = sisl_pkg::INDEX_DEPTH_DEF,
	parameter int DATA_DEPTH  = sisl_pkg::DATA_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire logic [sisl_pkg::OP_W-1:0]           opcode,
	input  wire logic signed [sisl_pkg::KEY_W-1:0]   query_key,
	input  wire logic signed [sisl_pkg::VAL_W-1:0]   entry_value,
	input  wire logic                                entry_tombstone,
	input  wire logic [sisl_pkg::POS_W-1:0]          entry_position,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic [sisl_pkg::STATUS_W-1:0]            status,
	output logic signed [sisl_pkg::VAL_W-1:0]        found_value
);
	import sisl_pkg::*;

	localparam int IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
	localparam int ICW = $clog2(INDEX_DEPTH + 1);
	localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int DCW = $clog2(DATA_DEPTH + 1);
	localparam int PW  = (DCW > POS_W) ? DCW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_IRD,
		S_ICMP,
		S_DRD,
		S_DCMP,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [ICW-1:0]          icnt_q;
	logic [DCW-1:0]          dcnt_q;
	logic [ICW-1:0]          lo_q;
	logic [ICW-1:0]          hi_q;
	logic [ICW-1:0]          mid_q;
	logic                    final_q;
	logic [PW-1:0]           ptr_q;
	logic signed [KEY_W-1:0] key_q;
	status_t                 res_status_q;
	logic signed [VAL_W-1:0] res_value_q;
	status_t                 status_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    rsp_valid_q;

	logic        accept;
	logic        out_free;
	logic        idx_has_room;
	logic        data_has_room;
	logic [ICW:0] lo_plus_one;
	logic [ICW:0] mid_sum;
	logic [ICW-1:0] mid_next;
	logic        search_more;
	logic        idx_le;
	logic        in_range;
	opcode_t     op;

	idx_entry_t  idx_wr;
	idx_entry_t  idx_rd;
	data_entry_t data_wr;
	data_entry_t data_rd;
	logic        idx_wr_en;
	logic        idx_rd_en;
	logic [IAW-1:0] idx_rd_addr;
	logic        data_wr_en;
	logic        data_rd_en;

	assign op            = opcode_t'(opcode);
	assign out_free      = !rsp_valid_q || !rsp_stall;
	assign req_stall     = (state_q != S_IDLE) || !out_free;
	assign accept        = req_valid && !req_stall;
	assign idx_has_room  = icnt_q < ICW'(INDEX_DEPTH);
	assign data_has_room = dcnt_q < DCW'(DATA_DEPTH);

	assign lo_plus_one = {1'b0, lo_q} + 1'b1;
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_next    = mid_sum[ICW:1];
	assign search_more = lo_plus_one < {1'b0, hi_q};
	assign idx_le      = idx_rd.key <= key_q;
	assign in_range    = ptr_q < PW'(dcnt_q);

	assign idx_wr.key    = query_key;
	assign idx_wr.pos    = entry_position;
	assign idx_wr_en     = accept && (op == OP_IDX_APPEND) && idx_has_room;
	assign idx_rd_en     = (state_q == S_IRD);
	assign idx_rd_addr   = search_more ? mid_next[IAW-1:0] : lo_q[IAW-1:0];

	assign data_wr.key   = query_key;
	assign data_wr.value = entry_value;
	assign data_wr.tomb  = entry_tombstone;
	assign data_wr_en    = accept && (op == OP_DATA_APPEND) && data_has_room;
	assign data_rd_en    = (state_q == S_DRD) && in_range;

	sisl_index_store #(
		.DEPTH(INDEX_DEPTH),
		.AW   (IAW)
	) u_index (
		.clk     (clk),
		.wr_en   (idx_wr_en),
		.wr_addr (icnt_q[IAW-1:0]),
		.wr_entry(idx_wr),
		.rd_en   (idx_rd_en),
		.rd_addr (idx_rd_addr),
		.rd_entry(idx_rd)
	);

	sisl_data_store #(
		.DEPTH(DATA_DEPTH),
		.AW   (DAW)
	) u_data (
		.clk     (clk),
		.wr_en   (data_wr_en),
		.wr_addr (dcnt_q[DAW-1:0]),
		.wr_entry(data_wr),
		.rd_en   (data_rd_en),
		.rd_addr (ptr_q[DAW-1:0]),
		.rd_entry(data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			icnt_q       <= '0;
			dcnt_q       <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			final_q      <= 1'b0;
			ptr_q        <= '0;
			key_q        <= '0;
			res_status_q <= ST_NOT_FOUND;
			res_value_q  <= '0;
			status_q     <= ST_NOT_FOUND;
			value_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q   <= query_key;
						value_q <= '0;
						case (op)
							OP_CLEAR: begin
								icnt_q      <= '0;
								dcnt_q      <= '0;
								status_q    <= ST_ACCEPTED;
								rsp_valid_q <= 1'b1;
							end
							OP_IDX_APPEND: begin
								if (idx_has_room) begin
									icnt_q   <= icnt_q + 1'b1;
									status_q <= ST_ACCEPTED;
								end else begin
									status_q <= ST_FULL;
								end
								rsp_valid_q <= 1'b1;
							end
							OP_DATA_APPEND: begin
								if (data_has_room) begin
									dcnt_q   <= dcnt_q + 1'b1;
									status_q <= ST_ACCEPTED;
								end else begin
									status_q <= ST_FULL;
								end
								rsp_valid_q <= 1'b1;
							end
							default: begin
								lo_q    <= '0;
								hi_q    <= icnt_q;
								ptr_q   <= '0;
								state_q <= (icnt_q == '0) ? S_DRD : S_IRD;
							end
						endcase
					end
				end
				S_IRD: begin
					mid_q   <= mid_next;
					final_q <= !search_more;
					state_q <= S_ICMP;
				end
				S_ICMP: begin
					if (!final_q) begin
						if (idx_le) begin
							lo_q <= mid_q;
						end else begin
							hi_q <= mid_q;
						end
						state_q <= S_IRD;
					end else begin
						ptr_q   <= idx_le ? PW'(idx_rd.pos) : '0;
						state_q <= S_DRD;
					end
				end
				S_DRD: begin
					if (!in_range) begin
						res_status_q <= ST_NOT_FOUND;
						res_value_q  <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_DCMP;
					end
				end
				S_DCMP: begin
					if (data_rd.key == key_q) begin
						if (data_rd.tomb) begin
							res_status_q <= ST_DELETED;
							res_value_q  <= '0;
						end else begin
							res_status_q <= ST_FOUND;
							res_value_q  <= data_rd.value;
						end
						state_q <= S_DONE;
					end else if (data_rd.key > key_q) begin
						res_status_q <= ST_NOT_FOUND;
						res_value_q  <= '0;
						state_q      <= S_DONE;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_DRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						status_q    <= res_status_q;
						value_q     <= res_value_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_value = value_q;

endmodule
`default_nettype wire

### rtl/sisl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sisl_checker
// Port-level checks of the lookup block, bound to its top level.
// ----------------------------------------------------------------------------
module sisl_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_stall,
	input wire logic [sisl_pkg::OP_W-1:0]         opcode,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_stall,
	input wire logic [sisl_pkg::STATUS_W-1:0]     status,
	input wire logic signed [sisl_pkg::VAL_W-1:0] found_value
);
	import sisl_pkg::*;

	logic req_beat;
	assign req_beat = req_valid && !req_stall;

	// A stalled response beat holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(found_value))
		else $error("stalled response changed");

	// Only a found result carries a value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_FOUND) |-> found_value == '0)
		else $error("value set on a result other than found");

	// A clear answers accepted in the next cycle.
	a_clear_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && (opcode == OP_CLEAR) |=> rsp_valid && (status == ST_ACCEPTED))
		else $error("clear did not answer accepted in the next cycle");

	// An append answers accepted or full in the next cycle.
	a_append_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && ((opcode == OP_IDX_APPEND) || (opcode == OP_DATA_APPEND))
		|=> rsp_valid && ((status == ST_ACCEPTED) || (status == ST_FULL)))
		else $error("append did not answer in the next cycle");

endmodule

bind sparse_index_sorted_lookup sisl_checker u_sisl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.opcode     (opcode),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.status     (status),
	.found_value(found_value)
);
`default_nettype wire
